FILE: src/middle_insert_queue_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef MIDDLE_INSERT_QUEUE_UNIT_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/miq_pkg.sv
`timescale 1ns / 1ps
package miq_pkg;

	// Command kinds; any kind with the high bit set is a pop.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BACK   = 2'd0;
	localparam kind_t KIND_MIDDLE = 2'd1;

	// Result status codes.
	typedef logic [1:0] res_t;
	localparam res_t RES_PUSHED = 2'd0;
	localparam res_t RES_POPPED = 2'd1;
	localparam res_t RES_EMPTY  = 2'd2;
	localparam res_t RES_FULL   = 2'd3;

	// Operation selected by the controller for the execute cycle.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_POP,
		OP_PUSH_BACK,
		OP_PUSH_MID
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIN
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
		res_t res;
		logic finish;
	} miq_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		kind_t kind;
		logic  front_empty;
		logic  full;
	} miq_stat_t;

endpackage

FILE: src/middle_insert_queue_unit.sv
`timescale 1ns / 1ps
// Channel   Transfer when     Signals
// command   start & !busy     kind, item_value
// result    done              popped_value, status
//
// A command's result is shown in the finish state after its execute state, for
// one cycle under done; a new command may be taken in that same cycle.
// Each command runs an execute state with one registered read of the half
// memories, then a finish state with the front-half write of a rebalance move.
// busy is high only in the execute cycle; the receiver cannot stall.
// Reset clears pointers and counts at once; memory contents are not cleared.
module middle_insert_queue_unit #(
	parameter int HALF_DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         kind,
	input  logic signed [31:0] item_value,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] popped_value,
	output logic [1:0]         status
);

	import miq_pkg::*;

	miq_cmd_t  cmd;
	miq_stat_t stat;

	miq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	miq_dp #(.HALF_DEPTH(HALF_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.item_value   (item_value),
		.stat         (stat),
		.popped_value (popped_value),
		.status       (status)
	);

endmodule

FILE: src/miq_ram.sv
`timescale 1ns / 1ps
module miq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/miq_ctrl.sv
`timescale 1ns / 1ps
module miq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  miq_pkg::miq_stat_t stat,
	output logic               busy,
	output logic               done,
	output miq_pkg::miq_cmd_t  cmd
);

	import miq_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a new transfer may be taken while the previous result is shown.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs and commands.
	always_comb begin
		busy       = (state_q == S_EXEC);
		done       = (state_q == S_FIN);
		cmd.load   = start && (state_q != S_EXEC);
		cmd.exec   = (state_q == S_EXEC);
		cmd.finish = (state_q == S_FIN);
		cmd.op     = OP_NONE;
		cmd.res    = RES_PUSHED;
		if (state_q == S_EXEC) begin
			case (stat.kind)
				KIND_BACK: begin
					cmd.op  = stat.full ? OP_NONE : OP_PUSH_BACK;
					cmd.res = stat.full ? RES_FULL : RES_PUSHED;
				end
				KIND_MIDDLE: begin
					cmd.op  = stat.full ? OP_NONE : OP_PUSH_MID;
					cmd.res = stat.full ? RES_FULL : RES_PUSHED;
				end
				default: begin
					cmd.op  = stat.front_empty ? OP_NONE : OP_POP;
					cmd.res = stat.front_empty ? RES_EMPTY : RES_POPPED;
				end
			endcase
		end
	end

endmodule

FILE: src/miq_dp.sv
`timescale 1ns / 1ps
module miq_dp #(
	parameter int HALF_DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  miq_pkg::miq_cmd_t  cmd,
	input  logic [1:0]         kind,
	input  logic signed [31:0] item_value,
	output miq_pkg::miq_stat_t stat,
	output logic signed [31:0] popped_value,
	output logic [1:0]         status
);

	import miq_pkg::*;

	localparam int AW = $clog2(HALF_DEPTH);
	localparam int CW = $clog2(HALF_DEPTH + 1);
	localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(HALF_DEPTH);
	localparam logic [CW:0]   FULL_CNT = (CW + 1)'(2 * HALF_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(HALF_DEPTH - 1);

	// Control state.
	logic [AW-1:0] fhead_q, bhead_q;
	logic [CW-1:0] fcnt_q, bcnt_q;
	logic          mv_q, pop_q;
	// Payload registers.
	kind_t         kind_q;
	logic [31:0]   value_q;
	res_t          res_q;
	logic [AW-1:0] fwa_q;

	logic [CW:0]   f_sum, b_sum, tot;
	logic [AW-1:0] f_tail, b_tail, fhead_inc, bhead_inc, bhead_dec;
	logic          equal, b_empty, mv_now;
	logic          f_we, f_re, b_we, b_re;
	logic [AW-1:0] f_waddr, b_waddr;
	logic [31:0]   f_wdata, f_rdata, b_rdata;

	// Index arithmetic on both circular halves.
	always_comb begin
		f_sum     = {1'b0, CW'(fhead_q)} + {1'b0, fcnt_q};
		b_sum     = {1'b0, CW'(bhead_q)} + {1'b0, bcnt_q};
		f_tail    = (f_sum >= DEPTH_S) ? AW'(f_sum - DEPTH_S) : AW'(f_sum);
		b_tail    = (b_sum >= DEPTH_S) ? AW'(b_sum - DEPTH_S) : AW'(b_sum);
		fhead_inc = (fhead_q == LAST_IDX) ? '0 : fhead_q + 1'b1;
		bhead_inc = (bhead_q == LAST_IDX) ? '0 : bhead_q + 1'b1;
		bhead_dec = (bhead_q == '0) ? LAST_IDX : bhead_q - 1'b1;
		tot       = {1'b0, fcnt_q} + {1'b0, bcnt_q};
		equal     = (fcnt_q == bcnt_q);
		b_empty   = (bcnt_q == '0);
	end

	// Status toward the controller.
	always_comb begin
		stat.kind        = kind_q;
		stat.front_empty = (fcnt_q == '0);
		stat.full        = (tot >= FULL_CNT);
	end

	// A move from the back head to the front tail is needed when the back half
	// would outgrow the front half.
	assign mv_now = cmd.exec && equal &&
		((cmd.op == OP_POP) || (cmd.op == OP_PUSH_BACK && !b_empty));

	// Memory port control.
	always_comb begin
		f_re    = cmd.exec && (cmd.op == OP_POP);
		f_we    = 1'b0;
		f_waddr = f_tail;
		f_wdata = value_q;
		if (cmd.finish && mv_q) begin
			f_we    = 1'b1;
			f_waddr = fwa_q;
			f_wdata = b_rdata;
		end else if (cmd.exec && equal &&
			((cmd.op == OP_PUSH_MID) || (cmd.op == OP_PUSH_BACK && b_empty))) begin
			f_we = 1'b1;
		end
		b_re    = mv_now;
		b_we    = 1'b0;
		b_waddr = b_tail;
		if (cmd.exec && cmd.op == OP_PUSH_BACK && !(equal && b_empty)) begin
			b_we = 1'b1;
		end else if (cmd.exec && cmd.op == OP_PUSH_MID && !equal) begin
			b_we    = 1'b1;
			b_waddr = bhead_dec;
		end
	end

	// Pointer and count updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fhead_q <= '0;
			bhead_q <= '0;
			fcnt_q  <= '0;
			bcnt_q  <= '0;
			mv_q    <= 1'b0;
			pop_q   <= 1'b0;
		end else if (cmd.exec) begin
			mv_q  <= mv_now;
			pop_q <= (cmd.op == OP_POP);
			case (cmd.op)
				OP_POP: begin
					fhead_q <= fhead_inc;
					if (mv_now) begin
						bhead_q <= bhead_inc;
						bcnt_q  <= bcnt_q - 1'b1;
					end else begin
						fcnt_q <= fcnt_q - 1'b1;
					end
				end
				OP_PUSH_BACK: begin
					if (equal) begin
						fcnt_q <= fcnt_q + 1'b1;
						if (!b_empty) begin
							bhead_q <= bhead_inc;
						end
					end else begin
						bcnt_q <= bcnt_q + 1'b1;
					end
				end
				OP_PUSH_MID: begin
					if (equal) begin
						fcnt_q <= fcnt_q + 1'b1;
					end else begin
						bhead_q <= bhead_dec;
						bcnt_q  <= bcnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input capture and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			value_q <= item_value;
		end
		if (cmd.exec) begin
			res_q <= cmd.res;
			fwa_q <= f_tail;
		end
	end

	miq_ram #(.WIDTH(32), .DEPTH(HALF_DEPTH)) u_front_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (fhead_q),
		.rdata (f_rdata)
	);

	miq_ram #(.WIDTH(32), .DEPTH(HALF_DEPTH)) u_back_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (value_q),
		.re    (b_re),
		.raddr (bhead_q),
		.rdata (b_rdata)
	);

	// Result outputs.
	assign popped_value = (cmd.finish && pop_q) ? f_rdata : '0;
	assign status       = res_q;

endmodule

FILE: src/miq_chk.sv
`timescale 1ns / 1ps
`include "middle_insert_queue_unit_macros.svh"
module miq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] popped_value,
	input logic [1:0]  status
);

	import miq_pkg::*;

	logic accept;
	assign accept = start && !busy;

	// An accepted command occupies the execute cycle next.
	`MIQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy && !done, "no execute after transfer")
	// Every execute cycle is followed by its result strobe.
	`MIQ_ASSERT_NEXT(a_accept_done, clk, arst_n, busy, done, "result strobe missing")
	// A result strobe is never shown without an execute cycle before it.
	`MIQ_ASSERT_NOW(a_done_cause, clk, arst_n, done, $past(busy), "result without command")
	// Only a successful pop carries a nonzero value.
	`MIQ_ASSERT_NOW(a_pop_zero, clk, arst_n, done && status != RES_POPPED,
		popped_value == '0, "value on a non-pop result")

endmodule

bind middle_insert_queue_unit miq_chk u_chk (.*);
